// File: design/sine_sample_generator_unit_macros.svh
// Assertion macros shared by the sine sample generator checkers.
// Included by the checker file; needs no package.
`ifndef SINE_SAMPLE_GENERATOR_UNIT_MACROS_SVH
`define SINE_SAMPLE_GENERATOR_UNIT_MACROS_SVH

// Overlapping implication: the consequent is checked in the same cycle.
`define SSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication: the consequent is checked in the next cycle.
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ssg_pkg.sv
// Shared types and constants of the sine sample generator.
// Used by every module of the block but the checker; depends on nothing.
`default_nettype none

package ssg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int PHASE_REG_W = 32;
   localparam int AMP_W       = 15;
   localparam int DC_W        = 16;
   localparam int RUN_W       = 16;
   localparam int SINE_W      = 15;
   localparam int REQ_DATA_W  = 8;

   // Quarter turn in radians, Q30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP  = 3'd0,
      CSR_PHASE_START = 3'd1,
      CSR_AMPLITUDE   = 3'd2,
      CSR_DC_OFFSET   = 3'd3,
      CSR_RUN_LENGTH  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_REG_W-1:0] phase_step;
      logic [PHASE_REG_W-1:0] phase_start;
      logic [AMP_W-1:0]       amplitude;
      logic [DC_W-1:0]        dc_offset;
      logic [RUN_W-1:0]       run_length;
   } cfg_type;

   // Load enables of the three pipeline registers.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } pipe_en_type;

endpackage

`default_nettype wire

// File: design/ssg_csr.sv
// Configuration register file of the sine sample generator.
// Depends on ssg_pkg for the register indexes and the settings struct.
`default_nettype none

module ssg_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ssg_pkg::cfg_type                 cfg
);

   ssg_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ssg_pkg::csr_index_type'(csr_index))
            ssg_pkg::CSR_PHASE_STEP:  cfg_in.phase_step  = csr_wdata;
            ssg_pkg::CSR_PHASE_START: cfg_in.phase_start = csr_wdata;
            ssg_pkg::CSR_AMPLITUDE:   cfg_in.amplitude   = csr_wdata[ssg_pkg::AMP_W-1:0];
            ssg_pkg::CSR_DC_OFFSET:   cfg_in.dc_offset   = csr_wdata[ssg_pkg::DC_W-1:0];
            ssg_pkg::CSR_RUN_LENGTH:  cfg_in.run_length  = csr_wdata[ssg_pkg::RUN_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{phase_step:  '0,
                     phase_start: '0,
                     amplitude:   '0,
                     dc_offset:   '0,
                     run_length:  ssg_pkg::RUN_W'(1)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ssg_phase.sv
// Phase accumulator and run counter of the sine sample generator.
// Depends on ssg_pkg for the settings struct.
`default_nettype none

module ssg_phase #(
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  restart,
   input  ssg_pkg::cfg_type      cfg,
   output logic [PHASE_BITS-1:0] phase,
   output logic                  last_ff
);

   logic [PHASE_BITS-1:0]         phase_acc_ff, phase_acc_in;
   logic [ssg_pkg::RUN_W-1:0]     sample_index_ff, sample_index_in, index_now;
   logic [ssg_pkg::RUN_W:0]       run_len;
   logic                          last_in;

   always_comb begin
      index_now = restart ? '0 : sample_index_ff;
      // The first sample of every run starts from the configured phase.
      phase     = (index_now == '0) ? PHASE_BITS'(cfg.phase_start) : phase_acc_ff;
      // A run length of zero behaves as one.
      run_len   = (cfg.run_length == '0) ? (ssg_pkg::RUN_W+1)'(1)
                                         : {1'b0, cfg.run_length};
      last_in   = ({1'b0, index_now} + (ssg_pkg::RUN_W+1)'(1)) >= run_len;
      sample_index_in = last_in ? '0 : index_now + ssg_pkg::RUN_W'(1);
      phase_acc_in    = phase + PHASE_BITS'(cfg.phase_step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         sample_index_ff <= '0;
      end else if (load) begin
         phase_acc_ff    <= phase_acc_in;
         sample_index_ff <= sample_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ssg_rom.sv
// Quarter-wave sine table with quadrant folding and a registered read.
// Depends on ssg_pkg for the entry width and the quarter-turn constant.
`default_nettype none

module ssg_rom #(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [PHASE_BITS-1:0]        phase,
   output logic [ssg_pkg::SINE_W-1:0]   mag_ff,
   output logic                         neg_ff
);

   localparam int ENTRIES = (1 << TABLE_ADDR_BITS) + 1;

   typedef logic [ssg_pkg::SINE_W-1:0] rom_array_type [0:ENTRIES-1];

   // One table entry: Taylor series of sin(x) through x^17/17!, Q30,
   // truncating at each step, clamped and rounded to unsigned Q0.15.
   function automatic logic [ssg_pkg::SINE_W-1:0] rom_entry(input logic [63:0] x);
      logic        [63:0] x2;
      logic        [63:0] t;
      logic signed [63:0] sum;
      logic        [63:0] scaled;
      x2  = (x * x) >> 30;
      t   = x;
      sum = signed'(x);
      t = ((t * x2) >> 30) / 64'd6;   sum = sum - signed'(t);
      t = ((t * x2) >> 30) / 64'd20;  sum = sum + signed'(t);
      t = ((t * x2) >> 30) / 64'd42;  sum = sum - signed'(t);
      t = ((t * x2) >> 30) / 64'd72;  sum = sum + signed'(t);
      t = ((t * x2) >> 30) / 64'd110; sum = sum - signed'(t);
      t = ((t * x2) >> 30) / 64'd156; sum = sum + signed'(t);
      t = ((t * x2) >> 30) / 64'd210; sum = sum - signed'(t);
      t = ((t * x2) >> 30) / 64'd272; sum = sum + signed'(t);
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      scaled = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      return scaled[ssg_pkg::SINE_W-1:0];
   endfunction

   function automatic rom_array_type build_rom();
      rom_array_type rom;
      for (int k = 0; k < ENTRIES; k++) begin
         rom[k] = rom_entry((ssg_pkg::HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS);
      end
      return rom;
   endfunction

   localparam rom_array_type SINE_ROM = build_rom();

   localparam logic [TABLE_ADDR_BITS:0] QUARTER = (TABLE_ADDR_BITS+1)'(1 << TABLE_ADDR_BITS);

   logic [TABLE_ADDR_BITS+1:0]   top_bits;
   logic [TABLE_ADDR_BITS-1:0]   index;
   logic [TABLE_ADDR_BITS:0]     addr;

   always_comb begin
      top_bits = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
      index    = top_bits[TABLE_ADDR_BITS-1:0];
      // Odd quadrants read the table backwards.
      addr     = top_bits[TABLE_ADDR_BITS] ? (QUARTER - {1'b0, index}) : {1'b0, index};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= SINE_ROM[addr];
         neg_ff <= top_bits[TABLE_ADDR_BITS+1];
      end
   end

endmodule

`default_nettype wire

// File: design/ssg_scale.sv
// Amplitude multiply, offset add and saturation of the sine sample generator.
// Depends on ssg_pkg for the settings struct, field widths and load enables.
`default_nettype none

module ssg_scale #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  ssg_pkg::pipe_en_type          en,
   input  ssg_pkg::cfg_type              cfg,
   input  logic [ssg_pkg::SINE_W-1:0]    mag,
   input  logic                          neg,
   input  logic                          last,
   output logic [SAMPLE_BITS-1:0]        sample_ff,
   output logic                          last_ff
);

   localparam int PROD_W = ssg_pkg::AMP_W + ssg_pkg::SINE_W;
   localparam int SUM_W  = ((SAMPLE_BITS > ssg_pkg::DC_W + 1) ? SAMPLE_BITS
                                                              : ssg_pkg::DC_W + 1) + 1;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

   logic [PROD_W-1:0]         product_ff;
   logic                      neg2_ff, last2_ff;
   logic signed [SUM_W-1:0]   magnitude, offset, total;
   logic [SAMPLE_BITS-1:0]    sample_in;

   always_ff @(posedge clock) begin
      if (en.s2) begin
         product_ff <= PROD_W'(cfg.amplitude) * PROD_W'(mag);
         neg2_ff    <= neg;
         last2_ff   <= last;
      end
   end

   always_comb begin
      magnitude = signed'(SUM_W'(product_ff[PROD_W-1:ssg_pkg::SINE_W]));
      offset    = SUM_W'(signed'(cfg.dc_offset));
      total     = (neg2_ff ? -magnitude : magnitude) + offset;
      if (total > SAT_MAX) begin
         sample_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (total < SAT_MIN) begin
         sample_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sample_in = total[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         sample_ff <= sample_in;
         last_ff   <= last2_ff;
      end
   end

endmodule

`default_nettype wire

// File: design/sine_sample_generator_unit.sv
// Top level of the sine sample generator: a table-based sine oscillator.
// Depends on ssg_pkg, ssg_csr, ssg_phase, ssg_rom and ssg_scale.
//
//   Channel   Direction  Carries
//   req_*     in         one sample request, restart flag in tdata bit 0
//   rsp_*     out        one signed sample in tdata, end of run on tlast
//   csr_*     in         register index and write data
//
// Each request yields one sample; one request is taken every cycle unless a
// stall has filled the pipeline. The three registers are the table read, the
// amplitude product and the output register; they move on independently, so
// bubbles close up while the output waits. Reset clears the settings (run
// length to one), the phase, the run counter and all stage valid flags.
`default_nettype none

module sine_sample_generator_unit #(
   parameter int  PHASE_BITS      = 32,
   parameter int  TABLE_ADDR_BITS = 10,
   parameter int  SAMPLE_BITS     = 16,
   localparam int RSP_DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ssg_pkg::REQ_DATA_W-1:0]   req_tdata,  // restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]            rsp_tdata,  // sample
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ssg_pkg::cfg_type             cfg;
   ssg_pkg::pipe_en_type         en;
   logic                         v1_ff, v2_ff, v3_ff;
   logic                         ready1, ready2, ready3;
   logic [PHASE_BITS-1:0]        phase;
   logic                         last1;
   logic [ssg_pkg::SINE_W-1:0]   mag1;
   logic                         neg1;
   logic [SAMPLE_BITS-1:0]       sample;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      ready3 = !v3_ff || rsp_tready;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;
      en.s1  = req_tvalid && ready1;
      en.s2  = ready2;
      en.s3  = ready3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_tvalid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   ssg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssg_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock   (clock),
      .reset   (reset),
      .load    (en.s1),
      .restart (req_tdata[0]),
      .cfg     (cfg),
      .phase   (phase),
      .last_ff (last1)
   );

   ssg_rom #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock  (clock),
      .load   (en.s1),
      .phase  (phase),
      .mag_ff (mag1),
      .neg_ff (neg1)
   );

   ssg_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .en        (en),
      .cfg       (cfg),
      .mag       (mag1),
      .neg       (neg1),
      .last      (last1),
      .sample_ff (sample),
      .last_ff   (rsp_tlast)
   );

   assign req_tready = ready1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = RSP_DATA_W'(sample);

endmodule

`default_nettype wire

// File: design/ssg_checker.sv
// Port-level checker of the sine sample generator, bound to the top level.
// Depends on sine_sample_generator_unit_macros.svh for the assertion macros.
`default_nettype none
`include "sine_sample_generator_unit_macros.svh"

module ssg_checker #(
   parameter int RSP_DATA_W = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A stalled result keeps its payload until the transaction completes.
   `SSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // Reset empties the pipeline.
   `SSG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // An accepted request must be followed by a valid result on the port.
   `SSG_ASSERT_SAME(a_latency, clock, reset, req_tvalid && req_tready, ##3 rsp_tvalid, "no result three cycles after a request")

   // With the output free, the block never refuses a request.
   `SSG_ASSERT_SAME(a_no_refusal, clock, reset, !rsp_tvalid, req_tready, "request refused with the output empty")

endmodule

bind sine_sample_generator_unit ssg_checker #(
   .RSP_DATA_W (RSP_DATA_W)
) u_ssg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
